@@ rtl/pbkdf_pkg.sv @@
// Package with shared types, constants and SHA-1 helpers for the PBKDF2 block.
`timescale 1ns / 1ps
package pbkdf_pkg;

  localparam int MaxPasswordBytes = 64;
  localparam int MaxSaltBytes     = 64;
  localparam int MaxKeyBytes      = 64;

  localparam logic [1:0] CMD_PASSWORD = 2'd0;
  localparam logic [1:0] CMD_SALT     = 2'd1;
  localparam logic [1:0] CMD_DERIVE   = 2'd2;

  localparam logic CFG_ITER   = 1'b0;
  localparam logic CFG_KEYLEN = 1'b1;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;

  // Source of each message byte while a block is assembled.
  typedef enum logic [2:0] {
    SRC_IPAD,
    SRC_OPAD,
    SRC_SALT,
    SRC_DIGEST,
    SRC_ZERO
  } src_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BLK_INIT,
    ST_HASH_INIT,
    ST_FILL,
    ST_FILL_WAIT,
    ST_COMPRESS,
    ST_COMP_DONE,
    ST_HASH_DONE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       hash_init;   // load SHA-1 initial value
    logic       fill_en;     // write one byte into the block buffer
    logic [5:0] fill_pos;
    logic [7:0] fill_byte;
    logic       round_start; // latch chaining value into working regs
    logic       round_en;    // one SHA-1 round
    logic [6:0] round_idx;
    logic       comp_add;    // add working regs into chaining value
    logic       save_inner;  // chaining value -> inner digest
    logic       save_u;      // chaining value -> previous U
    logic       acc_load;    // accumulator = chaining value
    logic       acc_xor;     // accumulator ^= chaining value
    logic [4:0] out_sel;     // byte of accumulator presented
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic [7:0] acc_byte;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

@@ rtl/pbkdf2_hmac_sha1_key_derivation.sv @@
// PBKDF2 with HMAC-SHA1: load password and salt bytes, derive key bytes.
//
// Input channel (in_valid / in_stall): each transfer carries a command.
// Password and salt loads sustain one per cycle while no derive is busy.
// Once a derive command is accepted, in_stall stays high until its last
// key byte is taken.
// Each SHA-1 compression fills the 64-byte block, loads the working
// registers, runs the 80 rounds and adds into the chaining value; an
// HMAC is four or five of them plus hash start and finish states. A 20-byte
// block takes a setup state and iteration_count HMACs on the single shared
// SHA-1 round unit; only the first HMAC of a block with a long salt needs five.
// key_length up to 64 needs up to four blocks.
// Output channel (out_valid / out_stall): key bytes in order, out_last on
// the final byte; while out_stall is high the byte is held and the
// computation waits.
// Configuration: cfg_we with cfg_index 0 writes iteration_count and
// index 1 writes key_length; write only while idle.
// Reset (rst_n low, synchronous) empties both stores and restores
// iteration_count 1 and key_length 20.
`timescale 1ns / 1ps
module pbkdf2_hmac_sha1_key_derivation #(
  parameter int MAX_PASSWORD_BYTES = pbkdf_pkg::MaxPasswordBytes,
  parameter int MAX_SALT_BYTES     = pbkdf_pkg::MaxSaltBytes,
  parameter int MAX_KEY_BYTES      = pbkdf_pkg::MaxKeyBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_key_byte,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import pbkdf_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [5:0] dig_sel;

  pbkdf_ctrl #(
    .MAX_PASSWORD_BYTES(MAX_PASSWORD_BYTES),
    .MAX_SALT_BYTES(MAX_SALT_BYTES),
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_data_byte(in_data_byte), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall), .out_key_byte(out_key_byte),
    .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .dig_sel(dig_sel), .stat(stat)
  );

  pbkdf_datapath u_dp (
    .clk(clk), .cmd(cmd), .dig_sel(dig_sel), .stat(stat)
  );
endmodule

@@ rtl/pbkdf_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module pbkdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/pbkdf_datapath.sv @@
// SHA-1 datapath: block buffer, round logic, chaining value, U and accumulator.
`timescale 1ns / 1ps
module pbkdf_datapath (
  input  logic               clk,
  input  pbkdf_pkg::dp_cmd_t cmd,
  input  logic [5:0]         dig_sel,
  output pbkdf_pkg::dp_stat_t stat
);
  import pbkdf_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] inner_r [5];
  logic [31:0] u_r [5];
  logic [31:0] acc_r [5];
  logic [31:0] wt, f, k, t;
  logic [3:0]  ri;
  logic [2:0]  dw;
  logic [1:0]  db;

  assign ri = cmd.round_idx[3:0];

  always_comb begin
    if (cmd.round_idx < 7'd16) begin
      wt = w_r[ri];
    end else begin
      wt = rotl(w_r[ri + 4'd13] ^ w_r[ri + 4'd8] ^ w_r[ri + 4'd2] ^ w_r[ri], 1);
    end
    if (cmd.round_idx < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = 32'h5A827999;
    end else if (cmd.round_idx < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = 32'h6ED9EBA1;
    end else if (cmd.round_idx < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r; k = 32'hCA62C1D6;
    end
    t = rotl(a_r, 5) + f + e_r + k + wt;
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_en) begin
      case (cmd.fill_pos[1:0])
        2'd0: w_r[cmd.fill_pos[5:2]][31:24] <= cmd.fill_byte;
        2'd1: w_r[cmd.fill_pos[5:2]][23:16] <= cmd.fill_byte;
        2'd2: w_r[cmd.fill_pos[5:2]][15:8]  <= cmd.fill_byte;
        default: w_r[cmd.fill_pos[5:2]][7:0] <= cmd.fill_byte;
      endcase
    end
    if (cmd.hash_init) begin
      h_r[0] <= 32'h67452301; h_r[1] <= 32'hEFCDAB89; h_r[2] <= 32'h98BADCFE;
      h_r[3] <= 32'h10325476; h_r[4] <= 32'hC3D2E1F0;
    end
    if (cmd.round_start) begin
      a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
    end
    if (cmd.round_en) begin
      if (cmd.round_idx >= 7'd16) begin
        w_r[ri] <= wt;
      end
      e_r <= d_r; d_r <= c_r; c_r <= rotl(b_r, 30); b_r <= a_r; a_r <= t;
    end
    if (cmd.comp_add) begin
      h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
    end
    for (int i = 0; i < 5; i++) begin
      if (cmd.save_inner) inner_r[i] <= h_r[i];
      if (cmd.save_u) u_r[i] <= h_r[i];
      if (cmd.acc_load) acc_r[i] <= h_r[i];
      if (cmd.acc_xor) acc_r[i] <= acc_r[i] ^ h_r[i];
    end
  end

  // dig_sel bit 5 high selects previous U, else the inner digest; low bits give byte.
  logic [4:0] ds;
  logic [31:0] dword, aword;
  always_comb begin
    ds = dig_sel[4:0];
    dw = ds[4:2];
    db = ds[1:0];
    dword = 32'd0;
    aword = 32'd0;
    for (int i = 0; i < 5; i++) begin
      if (dw == 3'(i)) dword = dig_sel[5] ? u_r[i] : inner_r[i];
      if (cmd.out_sel[4:2] == 3'(i)) aword = acc_r[i];
    end
    stat.digest_byte = 8'(dword >> (24 - 8 * db));
    stat.acc_byte    = 8'(aword >> (24 - 8 * cmd.out_sel[1:0]));
  end
endmodule

@@ rtl/pbkdf_ctrl.sv @@
// Controller: loads, message assembly, HMAC sequencing and key byte output.
`timescale 1ns / 1ps
module pbkdf_ctrl #(
  parameter int MAX_PASSWORD_BYTES = pbkdf_pkg::MaxPasswordBytes,
  parameter int MAX_SALT_BYTES     = pbkdf_pkg::MaxSaltBytes,
  parameter int MAX_KEY_BYTES      = pbkdf_pkg::MaxKeyBytes
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_data_byte,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_key_byte,
  output logic                out_last,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  output pbkdf_pkg::dp_cmd_t  cmd,
  output logic [5:0]          dig_sel,
  input  pbkdf_pkg::dp_stat_t stat
);
  import pbkdf_pkg::*;

  localparam int PW = $clog2(MAX_PASSWORD_BYTES + 1);
  localparam int SW = $clog2(MAX_SALT_BYTES + 1);
  localparam int PA = (MAX_PASSWORD_BYTES > 1) ? $clog2(MAX_PASSWORD_BYTES) : 1;
  localparam int SA = (MAX_SALT_BYTES > 1) ? $clog2(MAX_SALT_BYTES) : 1;

  state_t state_r, state_nxt;
  logic [31:0] iter_cfg_r;
  logic [6:0]  keylen_cfg_r;
  logic [PW-1:0] pw_cnt_r;
  logic [SW-1:0] salt_cnt_r;
  logic [31:0] iter_r, iter_nxt;
  logic [2:0]  blk_r, blk_nxt;
  logic [6:0]  emitted_r, emitted_nxt;
  logic [4:0]  bpos_r, bpos_nxt;
  logic        outer_r, outer_nxt;     // second hash of the HMAC
  logic [1:0]  cblk_r, cblk_nxt;       // compression index within hash
  logic [6:0]  fpos_r, fpos_nxt;       // fill cycle within block, 64 = last written
  logic [6:0]  rnd_r, rnd_nxt;
  logic [7:0]  fbyte_pend_r, fbyte_pend_nxt;
  src_t        src_pend_r, src_pend_nxt;
  logic        pend_r, pend_nxt;
  logic [5:0]  ppos_r, ppos_nxt;

  logic [6:0]  n_keys;
  logic [7:0]  msg_len;
  logic [8:0]  pad_len;
  logic [8:0]  total_len;
  logic [2:0]  nblk;
  logic [10:0] bits;
  logic        acc;
  logic [PA-1:0] pw_raddr;
  logic [SA-1:0] salt_raddr;
  logic [7:0]  pw_rdata, salt_rdata;
  logic        pw_we, salt_we;
  logic [PA-1:0] pw_waddr;
  logic [SA-1:0] salt_waddr;
  logic [7:0]  abs;    // absolute message byte index of fpos
  logic [7:0]  rel;    // position past the 64-byte pad block
  src_t        src;
  logic [7:0]  cbyte;
  logic [7:0]  pbyte;

  assign n_keys = (keylen_cfg_r > 7'(MAX_KEY_BYTES)) ? 7'(MAX_KEY_BYTES) : keylen_cfg_r;
  assign msg_len = outer_r ? 8'd84 : ((iter_r == 32'd1) ? 8'(64 + 4) + 8'(salt_cnt_r)
                                                         : 8'd84);
  assign pad_len = {1'b0, msg_len} + 9'd8;
  assign nblk = (pad_len >= 9'd192) ? 3'd4 : ((pad_len >= 9'd128) ? 3'd3 : 3'd2);
  assign total_len = {nblk, 6'd0};
  assign bits = {msg_len, 3'd0};
  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    pw_we = 1'b0; salt_we = 1'b0;
    pw_waddr = '0; salt_waddr = '0;
    if (acc && in_command == CMD_PASSWORD) begin
      pw_we = in_restart || (pw_cnt_r < PW'(MAX_PASSWORD_BYTES));
      pw_waddr = in_restart ? '0 : PA'(pw_cnt_r);
    end
    if (acc && in_command == CMD_SALT) begin
      salt_we = in_restart || (salt_cnt_r < SW'(MAX_SALT_BYTES));
      salt_waddr = in_restart ? '0 : SA'(salt_cnt_r);
    end
  end

  always_comb begin
    abs = {cblk_r, 6'd0} + {1'b0, fpos_r};
    rel = abs - 8'd64;
    pw_raddr = PA'(abs[5:0]);
    salt_raddr = SA'(rel);
    cbyte = 8'd0;
    src = SRC_ZERO;
    if (abs < 8'd64) begin
      src = outer_r ? SRC_OPAD : SRC_IPAD;
    end else if (abs < msg_len) begin
      if (outer_r || iter_r != 32'd1) begin
        src = SRC_DIGEST;
      end else if (rel < 8'(salt_cnt_r)) begin
        src = SRC_SALT;
      end else if (rel == 8'(salt_cnt_r) + 8'd3) begin
        cbyte = {5'd0, blk_r};
      end
    end else if (abs == msg_len) begin
      cbyte = 8'h80;
    end else if ({1'b0, abs} == total_len - 9'd2) begin
      cbyte = {5'd0, bits[10:8]};
    end else if ({1'b0, abs} == total_len - 9'd1) begin
      cbyte = bits[7:0];
    end
    dig_sel = {!outer_r, 5'(rel)};
  end

  pbkdf_ram #(.WIDTH(8), .DEPTH(MAX_PASSWORD_BYTES)) u_pw_ram (
    .clk(clk), .we(pw_we), .waddr(pw_waddr), .wdata(in_data_byte),
    .raddr(pw_raddr), .rdata(pw_rdata)
  );
  pbkdf_ram #(.WIDTH(8), .DEPTH(MAX_SALT_BYTES)) u_salt_ram (
    .clk(clk), .we(salt_we), .waddr(salt_waddr), .wdata(in_data_byte),
    .raddr(salt_raddr), .rdata(salt_rdata)
  );

  always_comb begin
    pbyte = fbyte_pend_r;
    case (src_pend_r)
      SRC_IPAD:   pbyte = (7'(ppos_r) < 7'(pw_cnt_r)) ? pw_rdata ^ IPAD : IPAD;
      SRC_OPAD:   pbyte = (7'(ppos_r) < 7'(pw_cnt_r)) ? pw_rdata ^ OPAD : OPAD;
      SRC_SALT:   pbyte = salt_rdata;
      SRC_DIGEST: pbyte = fbyte_pend_r;
      default:    pbyte = fbyte_pend_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt = iter_r; blk_nxt = blk_r; emitted_nxt = emitted_r; bpos_nxt = bpos_r;
    outer_nxt = outer_r; cblk_nxt = cblk_r; fpos_nxt = fpos_r;
    rnd_nxt = rnd_r;
    fbyte_pend_nxt = fbyte_pend_r; src_pend_nxt = src_pend_r; pend_nxt = 1'b0;
    ppos_nxt = ppos_r;
    cmd = '0;
    cmd.fill_en = pend_r;
    cmd.fill_pos = ppos_r;
    cmd.fill_byte = pbyte;
    cmd.round_idx = rnd_r;
    cmd.out_sel = bpos_r;
    out_valid = 1'b0;
    out_key_byte = stat.acc_byte;
    out_last = (emitted_r + 7'd1 == n_keys);
    case (state_r)
      ST_IDLE: begin
        if (acc && in_command == CMD_DERIVE && n_keys != 7'd0) begin
          blk_nxt = 3'd1; emitted_nxt = 7'd0;
          state_nxt = ST_BLK_INIT;
        end
      end
      ST_BLK_INIT: begin
        iter_nxt = 32'd1; outer_nxt = 1'b0;
        state_nxt = ST_HASH_INIT;
      end
      ST_HASH_INIT: begin
        cmd.hash_init = 1'b1;
        cblk_nxt = 2'd0; fpos_nxt = 7'd0;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        pend_nxt = 1'b1;
        ppos_nxt = fpos_r[5:0];
        src_pend_nxt = src;
        fbyte_pend_nxt = (src == SRC_DIGEST) ? stat.digest_byte : cbyte;
        fpos_nxt = fpos_r + 7'd1;
        if (fpos_r == 7'd63) state_nxt = ST_FILL_WAIT;
      end
      ST_FILL_WAIT: begin
        cmd.round_start = 1'b1;
        rnd_nxt = 7'd0;
        state_nxt = ST_COMPRESS;
      end
      ST_COMPRESS: begin
        cmd.round_en = 1'b1;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd79) state_nxt = ST_COMP_DONE;
      end
      ST_COMP_DONE: begin
        cmd.comp_add = 1'b1;
        fpos_nxt = 7'd0;
        if ({1'b0, cblk_r} + 3'd1 == nblk) begin
          state_nxt = ST_HASH_DONE;
        end else begin
          cblk_nxt = cblk_r + 2'd1;
          state_nxt = ST_FILL;
        end
      end
      ST_HASH_DONE: begin
        if (!outer_r) begin
          cmd.save_inner = 1'b1;
          outer_nxt = 1'b1;
          state_nxt = ST_HASH_INIT;
        end else begin
          cmd.save_u = 1'b1;
          outer_nxt = 1'b0;
          if (iter_r == 32'd1) cmd.acc_load = 1'b1;
          else cmd.acc_xor = 1'b1;
          if (iter_r >= iter_cfg_r) begin
            bpos_nxt = 5'd0;
            state_nxt = ST_EMIT;
          end else begin
            iter_nxt = iter_r + 32'd1;
            state_nxt = ST_HASH_INIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          emitted_nxt = emitted_r + 7'd1;
          bpos_nxt = bpos_r + 5'd1;
          if (emitted_r + 7'd1 == n_keys) begin
            state_nxt = ST_IDLE;
          end else if (bpos_r == 5'd19) begin
            blk_nxt = blk_r + 3'd1;
            state_nxt = ST_BLK_INIT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_cfg_r <= 32'd1;
      keylen_cfg_r <= 7'd20;
      pw_cnt_r <= '0;
      salt_cnt_r <= '0;
      iter_r <= 32'd0;
      blk_r <= 3'd0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r <= iter_nxt;
      blk_r <= blk_nxt;
      pend_r <= pend_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ITER:   iter_cfg_r <= cfg_data;
          CFG_KEYLEN: keylen_cfg_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (pw_we) pw_cnt_r <= PW'(pw_waddr) + PW'(1);
      if (salt_we) salt_cnt_r <= SW'(salt_waddr) + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    emitted_r <= emitted_nxt; bpos_r <= bpos_nxt; outer_r <= outer_nxt;
    cblk_r <= cblk_nxt; fpos_r <= fpos_nxt; rnd_r <= rnd_nxt;
    fbyte_pend_r <= fbyte_pend_nxt; src_pend_r <= src_pend_nxt; ppos_r <= ppos_nxt;
  end
endmodule

@@ tb/pbkdf2_key_checker.sv @@
// Checker that predicts derived key bytes from observed transfers and compares them.
`timescale 1ns / 1ps
module pbkdf2_key_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_key_byte,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  import pbkdf_pkg::*;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last;
  } key_out_t;

  key_out_t    key_queue[$];
  logic [7:0]  pw_store[0:63];
  logic [7:0]  salt_store[0:63];
  int          pw_count;
  int          salt_count;
  logic [31:0] iter_reg;
  logic [6:0]  klen_reg;
  logic        derive_seen;
  logic [7:0]  msg_buf[0:255];
  logic [7:0]  text_buf[0:67];

  function automatic logic [159:0] sha1_block(input logic [159:0] h, input int base);
    logic [31:0] w[0:15];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {msg_buf[base + 4 * i], msg_buf[base + 4 * i + 1],
              msg_buf[base + 4 * i + 2], msg_buf[base + 4 * i + 3]};
    end
    a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
    for (i = 0; i < 80; i++) begin
      if (i < 16) begin
        x = w[i];
      end else begin
        x = w[(i + 13) & 15] ^ w[(i + 8) & 15] ^ w[(i + 2) & 15] ^ w[i & 15];
        x = {x[30:0], x[31]};
        w[i & 15] = x;
      end
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + x;
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  function automatic logic [159:0] sha1_digest(input int len);
    logic [159:0] h;
    int total, bits, i;
    for (i = len; i < 256; i++) msg_buf[i] = 8'h00;
    msg_buf[len] = 8'h80;
    total = ((len + 8) / 64 + 1) * 64;
    bits = len * 8;
    msg_buf[total - 4] = bits[31:24];
    msg_buf[total - 3] = bits[23:16];
    msg_buf[total - 2] = bits[15:8];
    msg_buf[total - 1] = bits[7:0];
    h = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    for (i = 0; i < total; i += 64) h = sha1_block(h, i);
    return h;
  endfunction

  function automatic logic [159:0] hmac_password(input int tlen);
    logic [159:0] inner;
    logic [7:0] kb;
    int i;
    for (i = 0; i < 64; i++) begin
      kb = (i < pw_count) ? pw_store[i] : 8'h00;
      msg_buf[i] = kb ^ IPAD;
    end
    for (i = 0; i < tlen; i++) msg_buf[64 + i] = text_buf[i];
    inner = sha1_digest(64 + tlen);
    for (i = 0; i < 64; i++) begin
      kb = (i < pw_count) ? pw_store[i] : 8'h00;
      msg_buf[i] = kb ^ OPAD;
    end
    for (i = 0; i < 20; i++) msg_buf[64 + i] = inner[159 - 8 * i -: 8];
    return sha1_digest(84);
  endfunction

  task automatic predict_key();
    logic [159:0] u, acc;
    key_out_t item;
    int n, nblocks, rounds, emitted, blk, r, j;
    n = (klen_reg > MaxKeyBytes) ? MaxKeyBytes : klen_reg;
    nblocks = (n + 19) / 20;
    rounds = (iter_reg == 0) ? 1 : iter_reg;
    emitted = 0;
    for (blk = 1; blk <= nblocks; blk++) begin
      for (j = 0; j < salt_count; j++) text_buf[j] = salt_store[j];
      text_buf[salt_count] = 8'h00;
      text_buf[salt_count + 1] = 8'h00;
      text_buf[salt_count + 2] = 8'h00;
      text_buf[salt_count + 3] = blk[7:0];
      u = hmac_password(salt_count + 4);
      acc = u;
      for (r = 1; r < rounds; r++) begin
        for (j = 0; j < 20; j++) text_buf[j] = u[159 - 8 * j -: 8];
        u = hmac_password(20);
        acc ^= u;
      end
      for (j = 0; j < 20 && emitted < n; j++) begin
        item.key_byte = acc[159 - 8 * j -: 8];
        item.last = (emitted + 1 == n);
        key_queue.push_back(item);
        emitted++;
      end
    end
  endtask

  always @(posedge clk) begin
    key_out_t exp_item;
    if (!rst_n) begin
      key_queue.delete();
      pw_count = 0;
      salt_count = 0;
      iter_reg = 32'd1;
      klen_reg = 7'd20;
      derive_seen = 1'b0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ITER) iter_reg = cfg_data;
        else klen_reg = cfg_data[6:0];
      end
      // A derive is predicted when first presented, before its transfer
      // completes.
      if (in_valid && in_command == CMD_DERIVE && !derive_seen) begin
        predict_key();
        derive_seen = 1'b1;
      end
      if (in_valid && !in_stall) begin
        if (in_command == CMD_PASSWORD) begin
          if (in_restart) pw_count = 0;
          if (pw_count < MaxPasswordBytes) begin
            pw_store[pw_count] = in_data_byte;
            pw_count++;
          end
        end else if (in_command == CMD_SALT) begin
          if (in_restart) salt_count = 0;
          if (salt_count < MaxSaltBytes) begin
            salt_store[salt_count] = in_data_byte;
            salt_count++;
          end
        end
        derive_seen = 1'b0;
      end
      if (out_valid && !out_stall) begin
        if (key_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected key byte %02h last %0b", out_key_byte, out_last);
        end else begin
          exp_item = key_queue.pop_front();
          if (exp_item.key_byte !== out_key_byte || exp_item.last !== out_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("key byte mismatch: expected %02h last %0b, got %02h last %0b",
                       exp_item.key_byte, exp_item.last, out_key_byte, out_last);
          end
        end
      end
    end
    pending_count = key_queue.size();
  end
endmodule

@@ tb/tb_pbkdf2_hmac_sha1_key_derivation.sv @@
// Top of the testbench: drives configuration, password, salt and derive transfers and gives the verdict.
`timescale 1ns / 1ps
module tb_pbkdf2_hmac_sha1_key_derivation;
  import pbkdf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QuietLimit = 60000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [7:0]  in_data_byte;
  logic        in_restart;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_key_byte;
  logic        out_last;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_count;

  int          item_count;
  int          quiet_cycles;
  int          stall_hold;
  int          cur_rounds;
  logic        send_gaps;
  logic        stall_on;
  logic        silent_derive;

  pbkdf2_hmac_sha1_key_derivation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_data_byte(in_data_byte), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall), .out_key_byte(out_key_byte),
    .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pbkdf2_key_checker key_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_data_byte(in_data_byte), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall), .out_key_byte(out_key_byte),
    .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_hold = $urandom_range(1, 4);
    end
    out_stall <= (stall_hold != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input logic rst);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_byte <= data;
    in_restart <= rst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
    if (cmd == CMD_DERIVE && pending_count == 0) silent_derive = 1'b1;
  endtask

  task automatic load_store(input logic [1:0] cmd, input int len);
    int i;
    for (i = 0; i < len; i++) send_item(cmd, 8'($urandom_range(0, 255)), i == 0);
  endtask

  // Waits until every key byte has arrived; a derive that produced nothing
  // may still be busy, so it gets a generous extra wait.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    if (silent_derive) repeat (3500 * cur_rounds + 200) @(posedge clk);
    silent_derive = 1'b0;
  endtask

  task automatic write_cfg(input logic [31:0] iters, input logic [6:0] klen);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ITER;
    cfg_data <= iters;
    @(posedge clk);
    cfg_index <= CFG_KEYLEN;
    cfg_data <= {25'd0, klen};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_rounds = (iters == 0) ? 1 : iters;
  endtask

  function automatic logic [6:0] pick_klen();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd20;
      3: return 7'd21;
      4: return 7'd64;
      5: return 7'd127;
      6: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin
    int len;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_PASSWORD;
    in_data_byte <= 8'h00;
    in_restart <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ITER;
    cfg_data <= 32'd0;
    item_count = 0;
    cur_rounds = 1;
    send_gaps = 1'b1;
    stall_on = 1'b1;
    silent_derive = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty password and salt; restart on a derive is ignored.
    send_item(CMD_DERIVE, 8'hFF, 1'b1);
    send_item(CMD_UNUSED, 8'hFF, 1'b1);
    send_item(CMD_PASSWORD, 8'h00, 1'b1);
    send_item(CMD_PASSWORD, 8'hFF, 1'b0);
    send_item(CMD_DERIVE, 8'h00, 1'b0);
    send_item(CMD_SALT, 8'hFF, 1'b1);
    send_item(CMD_SALT, 8'h00, 1'b0);
    send_item(CMD_UNUSED, 8'h00, 1'b0);
    write_cfg(32'd0, 7'd1);
    send_item(CMD_DERIVE, 8'h5A, 1'b0);
    write_cfg(32'd2, 7'd64);
    send_item(CMD_DERIVE, 8'h00, 1'b0);
    write_cfg(32'd1, 7'd127);
    send_item(CMD_DERIVE, 8'h00, 1'b0);
    write_cfg(32'd3, 7'd0);
    send_item(CMD_DERIVE, 8'h00, 1'b0);
    write_cfg(32'd1, 7'd41);
    send_item(CMD_PASSWORD, 8'hA5, 1'b1);
    send_item(CMD_SALT, 8'h3C, 1'b1);
    send_item(CMD_DERIVE, 8'h00, 1'b1);

    while (item_count < 330) begin
      send_gaps = (item_count < 280) && ($urandom_range(0, 2) != 0);
      stall_on = (item_count < 280) && ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 2) == 0) write_cfg($urandom_range(0, 4), pick_klen());
      if ($urandom_range(0, 3) != 0) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        load_store(CMD_PASSWORD, len);
      end
      if ($urandom_range(0, 3) != 0) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        load_store(CMD_SALT, len);
      end
      if ($urandom_range(0, 4) == 0) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
      send_item(CMD_DERIVE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end

    settle();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
